### rtl/blake2b_hash_engine_macros.svh
// Assertion macros shared by the hash engine RTL.
`ifndef BLAKE2B_HASH_ENGINE_MACROS_SVH
`define BLAKE2B_HASH_ENGINE_MACROS_SVH
`ifndef SYNTH
`define B2B_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("hash engine assertion failed");
`define B2B_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("hash engine forbidden condition");
`else
`define B2B_ASSERT(lbl, prop)
`define B2B_NEVER(lbl, expr)
`endif
`endif

### rtl/b2b_pkg.sv
// Types and constants of the BLAKE2b hash engine.
`default_nettype none
package b2b_pkg;
	typedef enum logic [2:0] {
		ST_IDLE, ST_RESTART, ST_ABSORB, ST_LOAD, ST_RUN, ST_FOLD, ST_OUT
	} b2b_state_t;

	typedef logic [63:0] b2b_word_t;

	localparam b2b_word_t IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	localparam logic [6:0] DLEN_RESET = 7'd32;
	localparam logic [6:0] KLEN_RESET = 7'd0;
	localparam logic [0:0] REG_DLEN = 1'b0;
	localparam logic [0:0] REG_KLEN = 1'b1;
	localparam logic [0:0] CMD_ABSORB = 1'b0;
	localparam logic [0:0] CMD_FINISH = 1'b1;

	localparam logic [3:0] SIGMA [10][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

	// Clamped lengths folded into parameter word 0.
	function automatic logic [6:0] eff_dlen(input logic [6:0] raw);
		logic [6:0] r;
		r = raw;
		if (raw == 7'd0) r = 7'd1;
		else if (raw > 7'd64) r = 7'd64;
		return r;
	endfunction

	function automatic logic [6:0] eff_klen(input logic [6:0] raw);
		return (raw > 7'd64) ? 7'd64 : raw;
	endfunction

	function automatic b2b_word_t param_word(input logic [6:0] dl, input logic [6:0] kl);
		return {32'd0, 8'd1, 8'd1, 1'b0, kl, 1'b0, dl};
	endfunction
endpackage
`default_nettype wire

### rtl/b2b_g_unit.sv
// One half of the BLAKE2b mixing function on a column of the work vector.
`default_nettype none
module b2b_g_unit import b2b_pkg::*; (
	input  wire b2b_word_t a_in,
	input  wire b2b_word_t b_in,
	input  wire b2b_word_t c_in,
	input  wire b2b_word_t d_in,
	input  wire b2b_word_t m_in,
	input  wire logic      second,
	output b2b_word_t      a_out,
	output b2b_word_t      b_out,
	output b2b_word_t      c_out,
	output b2b_word_t      d_out
);
	b2b_word_t dx, bx;

	always_comb begin
		a_out = a_in + b_in + m_in;
		dx = d_in ^ a_out;
		// The first half rotates by 32 and 24, the second by 16 and 63.
		d_out = second ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
		c_out = c_in + d_out;
		bx = b_in ^ c_out;
		b_out = second ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
	end
endmodule
`default_nettype wire

### rtl/blake2b_hash_engine.sv
// BLAKE2b hash engine top level.
// One message at a time: an absorb that finds a full buffer first compresses it. A
// compression runs 12 rounds of 8 mixing steps, each split into two halves on one
// shared mixing unit, followed by a fold into the chain. Finish compresses the last
// block and then emits the digest words in order, each held until the sink takes it.
// A configuration write moves the engine to the restart state, which reinitializes
// the chain and clears the message.
`default_nettype none
`include "blake2b_hash_engine_macros.svh"
module blake2b_hash_engine import b2b_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // data_word, byte_count, zero pad
	input  wire logic [0:0]  s_tuser,  // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,  // digest_word, valid_bytes, zero pad
	output logic             m_tlast,
	output logic [0:0]       m_tuser   // misuse_error
);
	b2b_state_t state_q, state_next;
	logic [6:0] dlen_q, klen_q;
	b2b_word_t chain_q [8];
	b2b_word_t buf_q [16];
	b2b_word_t v_q [16];
	logic [7:0] fill_q;
	logic [127:0] cnt_q;
	logic partial_q, err_q, final_q;
	b2b_word_t word_q;
	logic [3:0] bc_q;
	logic [3:0] round_q;
	logic [2:0] g_q;
	logic half_q;
	logic [2:0] k_q;
	logic out_valid_q;
	b2b_word_t out_word_q;
	logic [3:0] out_vb_q;
	logic out_last_q, out_err_q;

	logic accept, out_take, cmd_finish;
	logic [3:0] bc_in;
	logic run_done, out_done;
	logic [6:0] dl_eff;
	logic [3:0] nw;
	logic [3:0] vb_next;
	b2b_word_t word_mask, msg_word;
	logic [3:0] sig_row, msg_idx;
	logic [4:0] words_filled;
	b2b_word_t ga, gb, gc, gd;
	b2b_word_t nv [16];
	b2b_word_t rv [16];
	logic [1:0] rot [4];

	assign accept = s_tvalid & s_tready;
	assign out_take = m_tvalid & m_tready;
	assign cmd_finish = (s_tuser == CMD_FINISH);
	assign bc_in = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
	assign run_done = (round_q == 4'd11) && (g_q == 3'd7) && half_q;
	assign out_done = out_take & out_last_q;
	assign dl_eff = eff_dlen(dlen_q);
	assign nw = 4'((dl_eff + 7'd7) >> 3);

	// Message word for the current half step; words past the filled region read as zero.
	assign sig_row = (round_q >= 4'd10) ? round_q - 4'd10 : round_q;
	assign msg_idx = SIGMA[sig_row][{g_q, half_q}];
	assign words_filled = 5'((9'(fill_q) + 9'd7) >> 3);
	assign msg_word = ({1'b0, msg_idx} < words_filled) ? buf_q[msg_idx] : '0;

	b2b_g_unit u_g (
		.a_in(v_q[0]), .b_in(v_q[4]), .c_in(v_q[8]), .d_in(v_q[12]),
		.m_in(msg_word), .second(half_q),
		.a_out(ga), .b_out(gb), .c_out(gc), .d_out(gd)
	);

	// The mixing unit always works on the first column. After each full step the rows
	// rotate so the next column or diagonal lands there; step 3 diagonalizes and step 7
	// restores the row order.
	always_comb begin
		for (int i = 0; i < 16; i++) nv[i] = v_q[i];
		nv[0] = ga;
		nv[4] = gb;
		nv[8] = gc;
		nv[12] = gd;
		for (int r = 0; r < 4; r++) begin
			if (!half_q) rot[r] = 2'd0;
			else if (g_q == 3'd3) rot[r] = 2'(r + 1);
			else if (g_q == 3'd7) rot[r] = 2'(1 - r);
			else rot[r] = 2'd1;
		end
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 4; j++) begin
				rv[4 * r + j] = nv[4 * r + 32'(2'(j + 32'(rot[r])))];
			end
		end
	end

	always_comb begin
		vb_next = ({1'b0, k_q} + 4'd1 < nw) ? 4'd8 : 4'(dl_eff - {1'b0, k_q, 3'd0});
		for (int i = 0; i < 8; i++) word_mask[8 * i +: 8] = (4'(i) < vb_next) ? 8'hFF : 8'h00;
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd_finish) state_next = ST_LOAD;
					else if (bc_in == 4'd0 || partial_q) state_next = ST_IDLE;
					else if (fill_q >= 8'd128) state_next = ST_LOAD;
					else state_next = ST_ABSORB;
				end
			end
			ST_RESTART: state_next = ST_IDLE;
			ST_ABSORB: state_next = ST_IDLE;
			ST_LOAD: state_next = ST_RUN;
			ST_RUN: if (run_done) state_next = ST_FOLD;
			ST_FOLD: state_next = final_q ? ST_OUT : ST_ABSORB;
			ST_OUT: if (out_done) state_next = ST_RESTART;
			default: state_next = ST_IDLE;
		endcase
		if (cfg_we) state_next = ST_RESTART;
	end

	// Handshake outputs.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = out_valid_q;
		m_tdata = {4'd0, out_vb_q, out_word_q};
		m_tlast = out_last_q;
		m_tuser = out_err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dlen_q <= DLEN_RESET;
			klen_q <= KLEN_RESET;
			for (int i = 1; i < 8; i++) chain_q[i] <= IV[i];
			chain_q[0] <= IV[0] ^ param_word(eff_dlen(DLEN_RESET), eff_klen(KLEN_RESET));
			fill_q <= '0;
			cnt_q <= '0;
			partial_q <= 1'b0;
			err_q <= 1'b0;
			final_q <= 1'b0;
			round_q <= '0;
			g_q <= '0;
			half_q <= 1'b0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				if (cfg_index == REG_DLEN) dlen_q <= cfg_data;
				else klen_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						word_q <= s_tdata[63:0];
						bc_q <= bc_in;
						if (cmd_finish) begin
							final_q <= 1'b1;
							cnt_q <= cnt_q + 128'(fill_q);
						end else if (bc_in != 4'd0 && partial_q) begin
							err_q <= 1'b1;
						end else if (bc_in != 4'd0 && fill_q >= 8'd128) begin
							final_q <= 1'b0;
							cnt_q <= cnt_q + 128'd128;
						end
					end
				end
				ST_RESTART: begin
					for (int i = 1; i < 8; i++) chain_q[i] <= IV[i];
					chain_q[0] <= IV[0] ^ param_word(dl_eff, eff_klen(klen_q));
					fill_q <= '0;
					cnt_q <= '0;
					partial_q <= 1'b0;
					err_q <= 1'b0;
					final_q <= 1'b0;
					k_q <= '0;
					out_valid_q <= 1'b0;
				end
				ST_ABSORB: begin
					fill_q <= fill_q + 8'(bc_q);
					if (bc_q < 4'd8) partial_q <= 1'b1;
				end
				ST_LOAD: begin
					for (int i = 0; i < 8; i++) begin
						v_q[i] <= chain_q[i];
					end
					v_q[8] <= IV[0];
					v_q[9] <= IV[1];
					v_q[10] <= IV[2];
					v_q[11] <= IV[3];
					v_q[12] <= IV[4] ^ cnt_q[63:0];
					v_q[13] <= IV[5] ^ cnt_q[127:64];
					v_q[14] <= final_q ? ~IV[6] : IV[6];
					v_q[15] <= IV[7];
					round_q <= '0;
					g_q <= '0;
					half_q <= 1'b0;
				end
				ST_RUN: begin
					for (int i = 0; i < 16; i++) v_q[i] <= rv[i];
					half_q <= ~half_q;
					if (half_q) begin
						g_q <= g_q + 3'd1;
						if (g_q == 3'd7) round_q <= round_q + 4'd1;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] ^ v_q[i] ^ v_q[i + 8];
					if (!final_q) fill_q <= '0;
					k_q <= '0;
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_word_q <= chain_q[k_q] & word_mask;
						out_vb_q <= vb_next;
						out_last_q <= ({1'b0, k_q} + 4'd1 == nw);
						out_err_q <= err_q;
						k_q <= k_q + 3'd1;
					end else if (out_take) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Block buffer storage, written at the fill position.
	always_ff @(posedge clk) begin
		if (state_q == ST_ABSORB) begin
			buf_q[fill_q[6:3]] <= word_q & {{8{bc_q > 4'd7}}, {8{bc_q > 4'd6}},
				{8{bc_q > 4'd5}}, {8{bc_q > 4'd4}}, {8{bc_q > 4'd3}},
				{8{bc_q > 4'd2}}, {8{bc_q > 4'd1}}, {8{bc_q > 4'd0}}};
		end
	end

	`B2B_NEVER(a_out_blocks_in, m_tvalid && s_tready)
	`B2B_NEVER(a_round_range, state_q == ST_RUN && round_q > 4'd11)
	`B2B_ASSERT(a_last_restarts, out_done && !cfg_we |=> state_q == ST_RESTART)
	`B2B_ASSERT(a_fill_bound, state_q == ST_ABSORB |-> fill_q < 8'd128)
endmodule
`default_nettype wire
